### design/dnsrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dnsrr_pkg;

  // Longest dotted owner name, in characters, that the parser accepts.
  localparam logic [7:0] NAME_MAX = 8'd255;

  // Either of the two top bits of a length byte marks a compression pointer.
  localparam logic [7:0] PTR_MASK = 8'hC0;
  localparam logic [15:0] CLASS_IN = 16'd1;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  // Type, class, TTL and rdlength follow the name.
  localparam int FIXED_BYTES = 2 + 2 + 4 + 2;
  localparam logic [3:0] FIXED_LAST = 4'(FIXED_BYTES - 1);
  localparam logic [3:0] TYPE_END = 4'd2;
  localparam logic [3:0] CLASS_END = 4'd4;
  localparam logic [3:0] TTL_END = 4'd8;

  typedef enum logic [1:0] {
    KIND_NAME_CHAR = 2'd0,
    KIND_RDATA     = 2'd1,
    KIND_DONE      = 2'd2,
    KIND_ERROR     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_INCOMPLETE = 2'd1,
    ERR_CLASS      = 2'd2,
    ERR_NAME_LONG  = 2'd3
  } err_e;

  typedef enum logic [6:0] {
    PH_FIRST = 7'b0000001,
    PH_NEXT  = 7'b0000010,
    PH_LABEL = 7'b0000100,
    PH_PTR2  = 7'b0001000,
    PH_FIXED = 7'b0010000,
    PH_RDATA = 7'b0100000,
    PH_DRAIN = 7'b1000000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [15:0] record_type;
    logic [31:0] time_to_live;
    logic [15:0] data_length;
    logic [7:0]  name_length;
    err_e        error_code;
  } result_t;

endpackage

`default_nettype wire

### design/dnsrr_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dnsrr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink (input valid, input in_byte, input buffer_end, output ready);
endinterface

`default_nettype wire

### design/dnsrr_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dnsrr_out_if;
  logic               valid;
  logic               ready;
  dnsrr_pkg::kind_e   kind;
  logic [7:0]         out_byte;
  logic [15:0]        record_type;
  logic [31:0]        time_to_live;
  logic [15:0]        data_length;
  logic [7:0]         name_length;
  dnsrr_pkg::err_e    error_code;

  modport source (
    output valid, output kind, output out_byte, output record_type,
    output time_to_live, output data_length, output name_length,
    output error_code, input ready
  );
  modport sink (
    input valid, input kind, input out_byte, input record_type,
    input time_to_live, input data_length, input name_length,
    input error_code, output ready
  );
endinterface

`default_nettype wire

### design/dns_resource_record_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming parser for the answer section of a DNS message.
// Bytes arrive on in_i, one request per byte, with buffer_end set on the
// last byte of the buffer. Each byte yields at most one result on out_o:
// a name character or dot, an rdata byte, a record done summary (type,
// TTL, rdlength, name length, sent on the final rdlength byte, before the
// rdata), or an error. The first length byte of a name, pointer bytes and
// most fixed-field bytes yield nothing; later length bytes yield a dot.
// After an error bytes are dropped up to the end of the buffer.
// Throughput is one byte per cycle while the skid register is empty: the
// per-byte parse step is a few levels of logic between the parse state
// and the output register, which drives the results on out_o.
// A skid register behind the output register lets one more byte be taken
// while the receiver stalls; in_i.ready drops only while that skid
// register is full.
// Reset empties both result registers and returns the parser to the
// start of a record, expecting the first name length byte.
module dns_resource_record_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dnsrr_in_if.sink    in_i,
  dnsrr_out_if.source out_o
);
  import dnsrr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  label_rem_q, label_rem_d;
  logic [3:0]  fcnt_q, fcnt_d;
  logic [7:0]  name_cnt_q, name_cnt_d;
  logic [15:0] type_q, type_d;
  logic [15:0] class_q, class_d;
  logic [31:0] ttl_q, ttl_d;
  logic [15:0] rdlen_q, rdlen_d;
  logic [15:0] rdrem_q, rdrem_d;

  logic        out_vld_q, skid_vld_q;
  result_t     out_q, skid_q;

  logic        accept;
  logic        out_free;
  logic [7:0]  b;
  logic        last;
  err_e        err;
  logic        has_kind;
  kind_e       kind;
  logic [7:0]  ob;
  logic        complete;
  logic        dropped;
  logic        produce;
  result_t     res;
  phase_e      len_phase;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign b        = in_i.in_byte;
  assign last     = in_i.buffer_end;

  // Phase that a name length byte leads to.
  always_comb begin
    if ((b & PTR_MASK) != 8'd0) begin
      len_phase = PH_PTR2;
    end else if (b == 8'd0) begin
      len_phase = PH_FIXED;
    end else begin
      len_phase = PH_LABEL;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    label_rem_d = label_rem_q;
    fcnt_d      = fcnt_q;
    name_cnt_d  = name_cnt_q;
    type_d      = type_q;
    class_d     = class_q;
    ttl_d       = ttl_q;
    rdlen_d     = rdlen_q;
    rdrem_d     = rdrem_q;
    err         = ERR_NONE;
    has_kind    = 1'b0;
    kind        = KIND_NAME_CHAR;
    ob          = 8'd0;
    complete    = 1'b0;
    dropped     = 1'b0;

    unique case (phase_q)
      PH_FIRST: begin
        name_cnt_d = 8'd0;
        type_d     = 16'd0;
        class_d    = 16'd0;
        ttl_d      = 32'd0;
        rdlen_d    = 16'd0;
        rdrem_d    = 16'd0;
        phase_d    = len_phase;
        if (len_phase == PH_FIXED) fcnt_d = 4'd0;
        if (len_phase == PH_LABEL) label_rem_d = b;
      end
      PH_NEXT: begin
        if (name_cnt_q >= NAME_MAX) begin
          err = ERR_NAME_LONG;
        end else begin
          has_kind   = 1'b1;
          kind       = KIND_NAME_CHAR;
          ob         = DOT_CHAR;
          name_cnt_d = name_cnt_q + 8'd1;
          phase_d    = len_phase;
          if (len_phase == PH_FIXED) fcnt_d = 4'd0;
          if (len_phase == PH_LABEL) label_rem_d = b;
        end
      end
      PH_LABEL: begin
        if (name_cnt_q >= NAME_MAX) begin
          err = ERR_NAME_LONG;
        end else begin
          has_kind   = 1'b1;
          kind       = KIND_NAME_CHAR;
          ob         = b;
          name_cnt_d = name_cnt_q + 8'd1;
          if (label_rem_q <= 8'd1) begin
            label_rem_d = 8'd0;
            phase_d     = PH_NEXT;
          end else begin
            label_rem_d = label_rem_q - 8'd1;
          end
        end
      end
      PH_PTR2: begin
        phase_d = PH_FIXED;
        fcnt_d  = 4'd0;
      end
      PH_FIXED: begin
        priority if (fcnt_q < TYPE_END) begin
          type_d = {type_q[7:0], b};
        end else if (fcnt_q < CLASS_END) begin
          class_d = {class_q[7:0], b};
        end else if (fcnt_q < TTL_END) begin
          ttl_d = {ttl_q[23:0], b};
        end else begin
          rdlen_d = {rdlen_q[7:0], b};
        end
        if (fcnt_q >= FIXED_LAST) begin
          fcnt_d = 4'd0;
          if (class_d != CLASS_IN) begin
            err = ERR_CLASS;
          end else begin
            has_kind = 1'b1;
            kind     = KIND_DONE;
            rdrem_d  = rdlen_d;
            if (rdlen_d == 16'd0) begin
              complete = 1'b1;
              phase_d  = PH_FIRST;
            end else begin
              phase_d = PH_RDATA;
            end
          end
        end else begin
          fcnt_d = fcnt_q + 4'd1;
        end
      end
      PH_RDATA: begin
        has_kind = 1'b1;
        kind     = KIND_RDATA;
        ob       = b;
        if (rdrem_q <= 16'd1) begin
          rdrem_d  = 16'd0;
          complete = 1'b1;
          phase_d  = PH_FIRST;
        end else begin
          rdrem_d = rdrem_q - 16'd1;
        end
      end
      default: begin
        // Dropping bytes after an error; unused codes behave the same.
        dropped = 1'b1;
        phase_d = last ? PH_FIRST : PH_DRAIN;
      end
    endcase

    if (!dropped && err == ERR_NONE && last && !complete) begin
      err = ERR_INCOMPLETE;
    end
    if (err != ERR_NONE) begin
      phase_d = last ? PH_FIRST : PH_DRAIN;
    end
  end

  always_comb begin
    res = '0;
    produce = 1'b0;
    if (err != ERR_NONE) begin
      produce        = 1'b1;
      res.kind       = KIND_ERROR;
      res.error_code = err;
    end else if (has_kind) begin
      produce  = 1'b1;
      res.kind = kind;
      if (kind == KIND_DONE) begin
        res.record_type  = type_d;
        res.time_to_live = ttl_d;
        res.data_length  = rdlen_d;
        res.name_length  = name_cnt_d;
      end else begin
        res.out_byte = ob;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      label_rem_q <= 8'd0;
      fcnt_q      <= 4'd0;
      name_cnt_q  <= 8'd0;
      type_q      <= 16'd0;
      class_q     <= 16'd0;
      ttl_q       <= 32'd0;
      rdlen_q     <= 16'd0;
      rdrem_q     <= 16'd0;
    end else if (accept) begin
      phase_q     <= phase_d;
      label_rem_q <= label_rem_d;
      fcnt_q      <= fcnt_d;
      name_cnt_q  <= name_cnt_d;
      type_q      <= type_d;
      class_q     <= class_d;
      ttl_q       <= ttl_d;
      rdlen_q     <= rdlen_d;
      rdrem_q     <= rdrem_d;
    end
  end

  // Output register with a skid register behind it. A byte is accepted
  // only while the skid register is empty.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= accept && produce;
      end
    end else if (accept && produce) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
      end else if (accept && produce) begin
        out_q <= res;
      end
    end else if (accept && produce) begin
      skid_q <= res;
    end
  end

  assign in_i.ready         = !skid_vld_q;
  assign out_o.valid        = out_vld_q;
  assign out_o.kind         = out_q.kind;
  assign out_o.out_byte     = out_q.out_byte;
  assign out_o.record_type  = out_q.record_type;
  assign out_o.time_to_live = out_q.time_to_live;
  assign out_o.data_length  = out_q.data_length;
  assign out_o.name_length  = out_q.name_length;
  assign out_o.error_code   = out_q.error_code;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a result while the output register is empty");

  a_error_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.kind == KIND_ERROR) |-> (out_q.error_code != ERR_NONE))
    else $error("error result without an error code");

  a_label_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_LABEL) |-> (label_rem_q != 8'd0))
    else $error("label phase with no label bytes left");

  a_rdata_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_RDATA) |-> (rdrem_q != 16'd0))
    else $error("rdata phase with no rdata bytes left");

  a_stall_takes_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_o.ready && accept && produce) |=> skid_vld_q)
    else $error("result taken during a stall was not held in the skid register");

endmodule

`default_nettype wire

### test/dns_resource_record_parser_tb.sv
`timescale 1ns / 1ps

module dns_resource_record_parser_tb;
  import dnsrr_pkg::*;

  typedef struct packed {
    bit         drain_first;
    logic       last;
    logic [7:0] value;
  } send_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  logic       in_valid = 1'b0;
  logic [7:0] in_byte = 8'd0;
  logic       in_last = 1'b0;
  logic       out_ready = 1'b0;

  dnsrr_in_if  in_bus ();
  dnsrr_out_if out_bus ();

  assign in_bus.valid      = in_valid;
  assign in_bus.in_byte    = in_byte;
  assign in_bus.buffer_end = in_last;
  assign out_bus.ready     = out_ready;

  dns_resource_record_parser DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  send_item_t bytes_to_send[$];
  result_t    results_due[$];
  logic [7:0] buf_q[$];

  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  int bytes_accepted = 0;
  int mismatch_count = 0;

  // Parser state as the block should hold it.
  phase_e      parse_ph = PH_FIRST;
  logic [7:0]  label_left = 8'd0;
  logic [3:0]  field_idx = 4'd0;
  logic [7:0]  name_len = 8'd0;
  logic [15:0] rr_type = 16'd0;
  logic [15:0] rr_class = 16'd0;
  logic [31:0] rr_ttl = 32'd0;
  logic [15:0] rr_rdlen = 16'd0;
  logic [15:0] rdata_left = 16'd0;

  // A length byte ends the name on zero, ends it on a pointer, or opens a label.
  function automatic void start_label(input logic [7:0] b);
    if ((b & PTR_MASK) != 8'd0) begin
      parse_ph = PH_PTR2;
    end else if (b == 8'd0) begin
      parse_ph  = PH_FIXED;
      field_idx = 4'd0;
    end else begin
      label_left = b;
      parse_ph   = PH_LABEL;
    end
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output result_t res);
    err_e       err;
    bit         has;
    bit         finished;
    kind_e      k;
    logic [7:0] ob;
    err      = ERR_NONE;
    has      = 1'b0;
    finished = 1'b0;
    k        = KIND_NAME_CHAR;
    ob       = 8'd0;
    res      = '0;
    case (parse_ph)
      PH_FIRST: begin
        name_len   = 8'd0;
        rr_type    = 16'd0;
        rr_class   = 16'd0;
        rr_ttl     = 32'd0;
        rr_rdlen   = 16'd0;
        rdata_left = 16'd0;
        start_label(b);
      end
      PH_NEXT: begin
        if (name_len >= NAME_MAX) begin
          err = ERR_NAME_LONG;
        end else begin
          has      = 1'b1;
          ob       = DOT_CHAR;
          name_len = name_len + 8'd1;
          start_label(b);
        end
      end
      PH_LABEL: begin
        if (name_len >= NAME_MAX) begin
          err = ERR_NAME_LONG;
        end else begin
          has      = 1'b1;
          ob       = b;
          name_len = name_len + 8'd1;
          if (label_left <= 8'd1) begin
            label_left = 8'd0;
            parse_ph   = PH_NEXT;
          end else begin
            label_left = label_left - 8'd1;
          end
        end
      end
      PH_PTR2: begin
        parse_ph  = PH_FIXED;
        field_idx = 4'd0;
      end
      PH_FIXED: begin
        if (field_idx < TYPE_END) rr_type = {rr_type[7:0], b};
        else if (field_idx < CLASS_END) rr_class = {rr_class[7:0], b};
        else if (field_idx < TTL_END) rr_ttl = {rr_ttl[23:0], b};
        else rr_rdlen = {rr_rdlen[7:0], b};
        if (field_idx >= FIXED_LAST) begin
          field_idx = 4'd0;
          if (rr_class != CLASS_IN) begin
            err = ERR_CLASS;
          end else begin
            has        = 1'b1;
            k          = KIND_DONE;
            rdata_left = rr_rdlen;
            if (rr_rdlen == 16'd0) begin
              finished = 1'b1;
              parse_ph = PH_FIRST;
            end else begin
              parse_ph = PH_RDATA;
            end
          end
        end else begin
          field_idx = field_idx + 4'd1;
        end
      end
      PH_RDATA: begin
        has = 1'b1;
        k   = KIND_RDATA;
        ob  = b;
        if (rdata_left <= 16'd1) begin
          rdata_left = 16'd0;
          finished   = 1'b1;
          parse_ph   = PH_FIRST;
        end else begin
          rdata_left = rdata_left - 16'd1;
        end
      end
      default: begin
        if (last) parse_ph = PH_FIRST;
        return 1'b0;
      end
    endcase

    if (err == ERR_NONE && last && !finished) err = ERR_INCOMPLETE;

    if (err != ERR_NONE) begin
      res.kind       = KIND_ERROR;
      res.error_code = err;
      parse_ph       = last ? PH_FIRST : PH_DRAIN;
      return 1'b1;
    end
    if (!has) return 1'b0;
    res.kind = k;
    if (k == KIND_DONE) begin
      res.record_type  = rr_type;
      res.time_to_live = rr_ttl;
      res.data_length  = rr_rdlen;
      res.name_length  = name_len;
    end else begin
      res.out_byte = ob;
    end
    return 1'b1;
  endfunction

  // Stimulus building: bytes collect in buf_q until the buffer is closed.
  task automatic add_byte(input logic [7:0] v);
    buf_q.push_back(v);
  endtask

  task automatic add_field(input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
  endtask

  task automatic close_buffer(input bit drain_first);
    send_item_t it;
    for (int i = 0; i < buf_q.size(); i++) begin
      it.drain_first = drain_first && (i == 0);
      it.last        = (i == buf_q.size() - 1);
      it.value       = buf_q[i];
      bytes_to_send.push_back(it);
    end
    buf_q.delete();
  endtask

  // Appends one record; cut_short is set when its rdata stops before rdlength.
  task automatic add_record(input int long_kind, output bit cut_short);
    int          labels;
    int          len;
    int          rdata_n;
    logic [15:0] rdlen;
    logic [31:0] ttl;
    cut_short = 1'b0;
    if (long_kind != 0) begin
      // Three full labels and a fourth that lands exactly on the limit,
      // or one byte over it.
      for (int i = 0; i < 4; i++) begin
        len = (i == 3 && long_kind == 1) ? 62 : 63;
        add_byte(8'(len));
        repeat (len) add_byte(8'($urandom));
      end
      add_byte(8'd0);
    end else begin
      labels = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
      for (int i = 0; i < labels; i++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 63) : $urandom_range(1, 12);
        add_byte(8'(len));
        repeat (len) add_byte(8'($urandom));
      end
      if ($urandom_range(0, 3) == 0) begin
        add_byte({2'($urandom_range(1, 3)), 6'($urandom)});
        add_byte(8'($urandom));
      end else begin
        add_byte(8'd0);
      end
    end
    add_field($urandom, 2);
    add_field(($urandom_range(0, 7) == 0) ? $urandom : 32'(CLASS_IN), 2);
    case ($urandom_range(0, 3))
      0: ttl = 32'd0;
      1: ttl = 32'hFFFF_FFFF;
      default: ttl = $urandom;
    endcase
    add_field(ttl, 4);
    case ($urandom_range(0, 9))
      8: rdlen = 16'($urandom_range(7, 40));
      9: begin
        rdlen     = 16'($urandom);
        cut_short = 1'b1;
      end
      default: rdlen = 16'($urandom_range(0, 6));
    endcase
    add_field(rdlen, 2);
    rdata_n = cut_short ? $urandom_range(0, 8) : rdlen;
    if (rdata_n > rdlen) rdata_n = rdlen;
    repeat (rdata_n) add_byte(8'($urandom));
  endtask

  task automatic make_buffer(input bit drain_first, input int long_kind, output int n);
    int nrec;
    int keep;
    bit cut;
    cut = 1'b0;
    if (long_kind == 0 && $urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 16)) add_byte(8'($urandom));
    end else begin
      nrec = $urandom_range(1, 3);
      for (int i = 0; i < nrec && !cut; i++) add_record((i == 0) ? long_kind : 0, cut);
      if ($urandom_range(0, 9) == 0) begin
        keep = $urandom_range(1, buf_q.size());
        while (buf_q.size() > keep) void'(buf_q.pop_back());
      end
    end
    n = buf_q.size();
    close_buffer(drain_first);
  endtask

  // Sender: one byte per request, a random gap after each accepted byte.
  int send_wait = 0;
  int sent_items = 0;
  bit send_quiet = 1'b0;

  always @(negedge clk_i) begin
    logic       offer;
    send_item_t nxt;
    offer = in_valid && !in_taken;
    if (rst_ni && !offer) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (bytes_to_send.size() != 0 &&
                   !(bytes_to_send[0].drain_first && results_due.size() != 0)) begin
        nxt = bytes_to_send.pop_front();
        in_byte <= nxt.value;
        in_last <= nxt.last;
        offer = 1'b1;
        sent_items++;
        if (sent_items % 40 == 0) send_quiet = ($urandom_range(0, 3) == 0);
        send_wait = send_quiet ? 0 : $urandom_range(0, 10);
      end
    end
    in_valid <= offer;
  end

  // One long hold on the output side once the stream is well under way.
  int hold_left = 0;
  bit hold_used = 1'b0;

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && bytes_accepted >= 150) begin
      hold_left <= 250;
      hold_used <= 1'b1;
    end
  end

  // Receiver: a random stall after each result it takes.
  int recv_wait = 0;
  int results_taken = 0;
  bit recv_quiet = 1'b0;

  always @(negedge clk_i) begin
    if (out_taken) begin
      results_taken++;
      if (results_taken % 40 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
      recv_wait = recv_quiet ? 0 : $urandom_range(0, 10);
    end
    out_ready <= rst_ni && recv_wait == 0 && hold_left == 0;
    if (recv_wait > 0) recv_wait--;
  end

  // Predict on every accepted request, check every accepted result.
  always @(posedge clk_i) begin
    result_t exp_res;
    result_t got;
    in_taken  <= rst_ni && in_valid && in_bus.ready;
    out_taken <= rst_ni && out_bus.valid && out_ready;
    if (rst_ni && in_valid && in_bus.ready) begin
      bytes_accepted++;
      if (parse_byte(in_byte, in_last, exp_res)) results_due.push_back(exp_res);
    end
    if (rst_ni && out_bus.valid && out_ready) begin
      got.kind         = out_bus.kind;
      got.out_byte     = out_bus.out_byte;
      got.record_type  = out_bus.record_type;
      got.time_to_live = out_bus.time_to_live;
      got.data_length  = out_bus.data_length;
      got.name_length  = out_bus.name_length;
      got.error_code   = out_bus.error_code;
      if (results_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result kind=%h byte=%h type=%h ttl=%h len=%h name=%h err=%h",
                   $time, got.kind, got.out_byte, got.record_type, got.time_to_live,
                   got.data_length, got.name_length, got.error_code);
      end else begin
        exp_res = results_due.pop_front();
        if (got.kind !== exp_res.kind || got.out_byte !== exp_res.out_byte ||
            got.record_type !== exp_res.record_type ||
            got.time_to_live !== exp_res.time_to_live ||
            got.data_length !== exp_res.data_length ||
            got.name_length !== exp_res.name_length ||
            got.error_code !== exp_res.error_code) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result mismatch", $time);
            $display("  expected kind=%h byte=%h type=%h ttl=%h len=%h name=%h err=%h",
                     exp_res.kind, exp_res.out_byte, exp_res.record_type,
                     exp_res.time_to_live, exp_res.data_length, exp_res.name_length,
                     exp_res.error_code);
            $display("  actual   kind=%h byte=%h type=%h ttl=%h len=%h name=%h err=%h",
                     got.kind, got.out_byte, got.record_type, got.time_to_live,
                     got.data_length, got.name_length, got.error_code);
          end
        end
      end
    end
  end

  initial begin
    int random_bytes;
    int buffers;
    int n;

    // Root name, all-ones type and TTL, no rdata, buffer ends with the record.
    add_byte(8'd0);
    add_field(32'hFFFF, 2);
    add_field(32'(CLASS_IN), 2);
    add_field(32'hFFFF_FFFF, 4);
    add_field(32'd0, 2);
    close_buffer(1'b0);
    // Buffer that ends right after the first label, before the name ends.
    add_byte(8'd1);
    add_byte(8'h61);
    close_buffer(1'b0);
    // Pointer as the first byte, then a class other than internet.
    add_byte(8'hC0);
    add_byte(8'h0C);
    add_field(32'd0, 2);
    add_field(32'd2, 2);
    add_field(32'd0, 4);
    add_field(32'd0, 2);
    close_buffer(1'b0);

    // The two long owner names come early so that both are always sent.
    random_bytes = 0;
    buffers = 0;
    while (random_bytes < 400 || buffers <= 4) begin
      make_buffer(buffers % 8 == 0, (buffers == 4) ? 1 : (buffers == 2) ? 2 : 0, n);
      if (buffers != 4 && buffers != 2) random_bytes += n;
      buffers++;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (bytes_to_send.size() != 0 || in_valid) @(negedge clk_i);
    while (results_due.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### filelist.f
design/dnsrr_pkg.sv
design/dnsrr_in_if.sv
design/dnsrr_out_if.sv
design/dns_resource_record_parser.sv
test/dns_resource_record_parser_tb.sv
